### hdl/etmt_pkg.sv
// shared types and constants of the encoder table match tracker
// beat structs, controller states, command and status groups
// no dependencies
package etmt_pkg;

    localparam int SENSOR_BITS  = 12;
    localparam int OFFSET_BITS  = 16;
    localparam int ANGLE_BITS   = 12;
    localparam int COST_SHIFT   = 4;
    localparam int TURN_COUNTS  = 4096;
    localparam int HALF_TURN    = 2048;

    // operation codes of an input beat
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [9:0]  entry_index;
        logic [11:0] entry_first;
        logic [11:0] entry_second;
        logic [11:0] sample_first;
        logic [11:0] sample_second;
        logic        clear_peak;
    } t_in;

    typedef struct packed {
        logic signed [31:0] position;
        logic [9:0]         best_index;
        logic [27:0]        peak_cost;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SQUARE,
        S_EVAL,
        S_NEXT,
        S_OFFRD,
        S_OFFSET,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        PH_COARSE0,
        PH_COARSE1,
        PH_PLUS,
        PH_MINUS
    } t_phase;

    typedef enum logic [2:0] {
        PR_HOLD,
        PR_COARSE,
        PR_TOWARD,
        PR_AWAY,
        PR_BEST
    } t_probe_op;

    typedef struct packed {
        logic      write;
        logic      start;
        logic      eval;
        logic      eval_first;
        logic      flip;
        logic      halve;
        t_probe_op probe_op;
        logic      offset;
        logic      finish;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic coarse2_ok;
        logic step_is_one;
    } t_status;

endpackage

### hdl/etmt_ctrl.sv
// search sequencer of the encoder table match tracker
// walks coarse probe, halving refinement, offset and angle update, result
// depends on etmt_pkg
module etmt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_op,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  etmt_pkg::t_status i_status,
    output etmt_pkg::t_cmd    o_cmd
);
    import etmt_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_COARSE0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_phase        = r_phase;
        n_out_valid    = r_out_valid && i_out_stall;
        o_cmd          = '0;
        o_cmd.probe_op = PR_HOLD;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op == OP_LOAD) begin
                        o_cmd.write = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_phase     = PH_COARSE0;
                        n_state     = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_SQUARE;
            end
            S_SQUARE: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval       = 1'b1;
                o_cmd.eval_first = (r_phase == PH_COARSE0);
                n_state          = S_NEXT;
            end
            S_NEXT: begin
                case (r_phase)
                    PH_COARSE0: begin
                        if (i_status.coarse2_ok) begin
                            o_cmd.probe_op = PR_COARSE;
                            n_phase        = PH_COARSE1;
                        end else begin
                            o_cmd.halve    = 1'b1;
                            o_cmd.probe_op = PR_TOWARD;
                            n_phase        = PH_PLUS;
                        end
                        n_state = S_READ;
                    end
                    PH_COARSE1: begin
                        o_cmd.halve    = 1'b1;
                        o_cmd.probe_op = PR_TOWARD;
                        n_phase        = PH_PLUS;
                        n_state        = S_READ;
                    end
                    PH_PLUS: begin
                        if (i_status.hit) begin
                            if (i_status.step_is_one) begin
                                o_cmd.probe_op = PR_BEST;
                                n_state        = S_OFFRD;
                            end else begin
                                o_cmd.flip     = 1'b1;
                                o_cmd.halve    = 1'b1;
                                o_cmd.probe_op = PR_TOWARD;
                                n_state        = S_READ;
                            end
                        end else begin
                            o_cmd.probe_op = PR_AWAY;
                            n_phase        = PH_MINUS;
                            n_state        = S_READ;
                        end
                    end
                    PH_MINUS: begin
                        if (i_status.step_is_one) begin
                            o_cmd.probe_op = PR_BEST;
                            n_state        = S_OFFRD;
                        end else begin
                            o_cmd.halve    = 1'b1;
                            o_cmd.probe_op = PR_TOWARD;
                            n_phase        = PH_PLUS;
                            n_state        = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_OFFRD: begin
                n_state = S_OFFSET;
            end
            S_OFFSET: begin
                o_cmd.offset = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hdl/etmt_datapath.sv
// datapath of the encoder table match tracker: calibration table memory,
// cost unit, probe index logic, offset and turn tracking, angle scaling
// depends on etmt_pkg
module etmt_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  etmt_pkg::t_in     i_in_data,
    input  etmt_pkg::t_cmd    i_cmd,
    output etmt_pkg::t_status o_status,
    output etmt_pkg::t_out    o_out_data
);
    import etmt_pkg::*;

    localparam int IW         = $clog2(TABLE_DEPTH);
    localparam int STEP0      = TABLE_DEPTH / 2 + 1;
    localparam int SW         = $clog2(STEP0 + 1);
    localparam int MOVE_LIMIT = TABLE_DEPTH / 10;

    // angle = floor(best * 4096 / depth) as (best * recip) >> (2 * IW)
    localparam int RECIP_SHIFT = 2 * IW;
    localparam int RECIP_BITS  = IW + 14;
    localparam int PROD_BITS   = IW + RECIP_BITS;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << (RECIP_SHIFT + ANGLE_BITS)) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_FULL[RECIP_BITS-1:0];

    localparam logic signed [IW+1:0]     DEPTH_S  = (IW+2)'(TABLE_DEPTH);
    localparam logic [IW:0]              DEPTH_U  = (IW+1)'(TABLE_DEPTH);
    localparam logic signed [IW+1:0]     LIMIT_S  = (IW+2)'(MOVE_LIMIT);
    localparam logic signed [ANGLE_BITS:0] HALF_POS = (ANGLE_BITS+1)'(HALF_TURN);
    localparam logic signed [ANGLE_BITS:0] HALF_NEG = -(ANGLE_BITS+1)'(HALF_TURN);
    localparam logic [31:0]              TURN_STEP = 32'(TURN_COUNTS);

    function automatic logic [IW-1:0] wrap_idx(input logic signed [IW+1:0] v);
        logic signed [IW+1:0] w;
        if (v >= DEPTH_S) begin
            w = v - DEPTH_S;
        end else if (v < 0) begin
            w = v + DEPTH_S;
        end else begin
            w = v;
        end
        return w[IW-1:0];
    endfunction

    // calibration table
    logic [SENSOR_BITS-1:0] r_tab_first  [TABLE_DEPTH];
    logic [SENSOR_BITS-1:0] r_tab_second [TABLE_DEPTH];
    logic [SENSOR_BITS-1:0] r_rd_first, r_rd_second;

    // per sample working registers
    logic [SENSOR_BITS-1:0] r_raw1, r_raw2;
    logic [OFFSET_BITS-1:0] r_s1, r_s2;
    logic                   r_clr;
    logic [IW-1:0]          r_probe, r_best;
    logic [31:0]            r_best_cost;
    logic [31:0]            r_sq1, r_sq2;
    logic                   r_hit;
    logic [SW-1:0]          r_step;
    logic                   r_dir_neg;
    logic [ANGLE_BITS-1:0]  r_quo;
    t_out                   r_out;

    // tracked state
    logic signed [OFFSET_BITS-1:0] r_offset;
    logic [IW-1:0]          r_ias, r_prev, r_pred;
    logic [ANGLE_BITS-1:0]  r_last;
    logic [31:0]            r_turn;
    logic [27:0]            r_peak;

    logic [IW:0]            wr_ext;
    logic                   wr_ok;
    logic signed [OFFSET_BITS-1:0] off_adj, off_q;
    logic [OFFSET_BITS-1:0] s1_new, s2_new;
    logic signed [16:0]     da1, da2;
    logic signed [33:0]     sq1_full, sq2_full;
    logic [31:0]            cost;
    logic                   hit;
    logic [IW:0]            coarse_sum;
    logic                   n_dir_neg, go_neg;
    logic [SW-1:0]          n_step;
    logic signed [IW+1:0]   base, delta_s, cand;
    logic signed [IW+1:0]   d_move, d_abs;
    logic                   moved;
    logic signed [13:0]     cur_sum, cur_adj, cur_half;
    logic signed [19:0]     so_ext, w, w_adj, w_q;
    logic [OFFSET_BITS-1:0] n_offset;
    logic signed [IW+1:0]   pv;
    logic [27:0]            peak_cand;
    logic [PROD_BITS-1:0]   angle_prod;
    logic signed [ANGLE_BITS:0] delta_a;
    logic [31:0]            n_turn;
    logic [IW:0]            best_ext;

    // table write and registered read
    assign wr_ext = (IW+1)'(i_in_data.entry_index);
    assign wr_ok  = (wr_ext < DEPTH_U);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && wr_ok) begin
            r_tab_first[wr_ext[IW-1:0]]  <= i_in_data.entry_first;
            r_tab_second[wr_ext[IW-1:0]] <= i_in_data.entry_second;
        end
        r_rd_first  <= r_tab_first[r_probe];
        r_rd_second <= r_tab_second[r_probe];
    end

    // offset removal, truncating toward zero
    assign off_adj = r_offset + (r_offset[OFFSET_BITS-1] ? 16'sd15 : 16'sd0);
    assign off_q   = off_adj >>> 4;
    assign s1_new  = {4'b0, i_in_data.sample_first} - off_q;
    assign s2_new  = {4'b0, i_in_data.sample_second} - off_q;

    // cost unit
    assign da1      = $signed({5'b0, r_rd_first}) - $signed({1'b0, r_s1});
    assign da2      = $signed({5'b0, r_rd_second}) - $signed({1'b0, r_s2});
    assign sq1_full = 34'(da1) * 34'(da1);
    assign sq2_full = 34'(da2) * 34'(da2);
    assign cost     = r_sq1 + r_sq2;
    assign hit      = i_cmd.eval_first || (cost < r_best_cost);

    // probe index
    assign coarse_sum = {1'b0, r_best} + (IW+1)'(STEP0);
    assign n_dir_neg  = i_cmd.flip ? ~r_dir_neg : r_dir_neg;
    assign n_step     = i_cmd.halve ? (r_step >> 1) : r_step;
    assign go_neg     = n_dir_neg ^ (i_cmd.probe_op == PR_AWAY);
    assign base       = $signed({2'b0, r_best});
    assign delta_s    = $signed({{(IW+2-SW){1'b0}}, n_step});
    assign cand       = go_neg ? (base - delta_s) : (base + delta_s);

    // offset tracking from the best entry
    assign d_move   = base - $signed({2'b0, r_ias});
    assign d_abs    = d_move[IW+1] ? -d_move : d_move;
    assign moved    = (d_abs > LIMIT_S);
    assign cur_sum  = {2'b0, r_raw1} - {2'b0, r_rd_first} + {2'b0, r_raw2} - {2'b0, r_rd_second};
    assign cur_adj  = cur_sum + (cur_sum[13] ? 14'sd1 : 14'sd0);
    assign cur_half = cur_adj >>> 1;
    assign so_ext   = {{4{r_offset[OFFSET_BITS-1]}}, r_offset};
    assign w        = (so_ext <<< 4) - so_ext;
    assign w_adj    = w + (w[19] ? 20'sd15 : 20'sd0);
    assign w_q      = w_adj >>> 4;
    assign n_offset = w_q[OFFSET_BITS-1:0] + {{2{cur_half[13]}}, cur_half};

    // next index prediction
    assign pv = $signed({1'b0, r_best, 1'b0}) - $signed({2'b0, r_prev});

    assign peak_cand = r_best_cost[31:COST_SHIFT];

    // angle scaling by the reciprocal of the depth
    assign angle_prod = PROD_BITS'(r_best) * PROD_BITS'(RECIP);

    // turn counting
    assign delta_a  = $signed({1'b0, r_quo}) - $signed({1'b0, r_last});
    assign n_turn   = (delta_a > HALF_POS) ? (r_turn - TURN_STEP) :
                      (delta_a < HALF_NEG) ? (r_turn + TURN_STEP) : r_turn;
    assign best_ext = {1'b0, r_best};

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_raw1    <= i_in_data.sample_first;
            r_raw2    <= i_in_data.sample_second;
            r_s1      <= s1_new;
            r_s2      <= s2_new;
            r_clr     <= i_in_data.clear_peak;
            r_step    <= SW'(STEP0);
            r_dir_neg <= 1'b0;
            r_probe   <= r_pred;
        end else begin
            case (i_cmd.probe_op)
                PR_COARSE:           r_probe <= coarse_sum[IW-1:0];
                PR_TOWARD, PR_AWAY:  r_probe <= wrap_idx(cand);
                PR_BEST:             r_probe <= r_best;
                default:             r_probe <= r_probe;
            endcase
            if (i_cmd.halve) begin
                r_step <= n_step;
            end
            if (i_cmd.flip) begin
                r_dir_neg <= n_dir_neg;
            end
        end
        r_sq1 <= sq1_full[31:0];
        r_sq2 <= sq2_full[31:0];
        if (i_cmd.eval) begin
            r_hit <= hit;
            if (hit) begin
                r_best      <= r_probe;
                r_best_cost <= cost;
            end
        end
        if (i_cmd.offset) begin
            r_quo <= angle_prod[RECIP_SHIFT+ANGLE_BITS-1:RECIP_SHIFT];
        end
        if (i_cmd.finish) begin
            r_out.position   <= n_turn + 32'(r_quo);
            r_out.best_index <= best_ext[9:0];
            r_out.peak_cost  <= r_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_ias    <= '0;
            r_prev   <= '0;
            r_pred   <= '0;
            r_last   <= '0;
            r_turn   <= '0;
            r_peak   <= '0;
        end else begin
            if (i_cmd.offset) begin
                if (moved) begin
                    r_ias    <= r_best;
                    r_offset <= n_offset;
                end
                r_prev <= r_best;
                r_pred <= wrap_idx(pv);
                if (peak_cand > r_peak) begin
                    r_peak <= peak_cand;
                end
            end
            if (i_cmd.finish) begin
                r_turn <= n_turn;
                r_last <= r_quo;
                if (r_clr) begin
                    r_peak <= '0;
                end
            end
        end
    end

    assign o_status.hit         = r_hit;
    assign o_status.coarse2_ok  = (coarse_sum < DEPTH_U);
    assign o_status.step_is_one = (r_step == SW'(1));
    assign o_out_data           = r_out;

endmodule

### hdl/encoder_table_match_tracker.sv
// Optical encoder table match tracker. A load beat (op = load) writes one entry of a
// two-column calibration table; entry indexes at or beyond TABLE_DEPTH are dropped. A
// sample beat takes two sensor levels, removes the tracked common offset (16-bit wrap),
// and searches the table for the entry of least squared distance: a probe at the
// predicted index plus one TABLE_DEPTH/2+1 entries on if that stays inside the table,
// then a halving refinement that tries the current direction first and reverses after
// each gain. It then refreshes the offset after a large move, predicts the next index,
// and returns one result beat with the position (angle plus turn count, 4096 counts
// per turn), the best index and the peak cost (best cost / 16, cleared after the result
// when clear_peak is set). Loads give no result. Every table entry the search can reach
// must be loaded before the first sample. The search runs on one table read port and
// one cost unit; each probe steps through read, square, sum and compare, next index.
// With H halvings from TABLE_DEPTH/2+1 down to 1 (9 for a depth of 1024) a sample uses
// P = H+1 to 2H+2 probes. The best entry is then reread, the offset and angle updated
// and the result put in the output register, and the block returns to idle for the
// next beat. The angle is scaled by a multiply with the reciprocal of TABLE_DEPTH. The
// next beat is taken once the result sits in the output register, even while that
// result is still stalled; a new result waits in its last step while the previous
// one is still stalled.
// depends on etmt_pkg, etmt_ctrl, etmt_datapath
module encoder_table_match_tracker #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // input beats: table loads and sensor samples
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  etmt_pkg::t_in  i_in_data,
    // result beats, one per sample
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output etmt_pkg::t_out o_out_data
);
    import etmt_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: accepts beats only when idle, steps the search and
    // holds the result valid until the downstream side takes it
    etmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_data.op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // table memory, cost unit, tracking state and output register
    etmt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

### tb/encoder_table_match_tracker_tb.sv
// self-checking testbench for encoder_table_match_tracker: table loads, sensor samples
// and a beat-level predictor of the table search, offset tracking and turn counting
// depends on etmt_pkg and encoder_table_match_tracker
`timescale 1ns / 100ps

module encoder_table_match_tracker_tb;

    import etmt_pkg::*;

    localparam int DEPTH          = 1024;
    localparam int QUARTER        = DEPTH / 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 4000;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_stall = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    // idle rates in percent, changed per phase by the test sequence
    int send_idle_pct = 0;
    int out_stall_pct = 0;

    // long receiver hold-off, requested by the test and counted in the stall process
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    int mismatches   = 0;
    int quiet_cycles = 0;

    // predictor copy of the block state
    logic [11:0] cal_first  [DEPTH];
    logic [11:0] cal_second [DEPTH];
    int          offset_est   = 0;
    int          anchor_index = 0;
    int          prev_best    = 0;
    int          pred_index   = 0;
    int          prev_angle   = 0;
    logic [31:0] turn_counts  = '0;
    logic [27:0] peak_level   = '0;

    // results still owed by the block, oldest first
    t_out position_fixes [$];

    encoder_table_match_tracker #(
        .TABLE_DEPTH (DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    // probe indexes wrap once around the table
    function automatic int ring(input int v);
        if (v >= DEPTH)
            v -= DEPTH;
        else if (v < 0)
            v += DEPTH;
        return v;
    endfunction

    // squared distance, every term wrapping at 32 bits
    function automatic logic [31:0] sq_cost(input int idx, input logic [31:0] s1,
                                            input logic [31:0] s2);
        logic [31:0] da;
        logic [31:0] db;
        da = {20'd0, cal_first[idx]} - s1;
        db = {20'd0, cal_second[idx]} - s2;
        return da * da + db * db;
    endfunction

    function automatic void store_entry(input t_in beat);
        // indexes at or beyond the depth are dropped by the block
        if (int'(beat.entry_index) < DEPTH) begin
            cal_first[beat.entry_index]  = beat.entry_first;
            cal_second[beat.entry_index] = beat.entry_second;
        end
    endfunction

    // search, offset refresh, prediction, peak and turns for one sample beat
    function automatic t_out track_sample(input t_in beat);
        t_out               fix;
        int                 raw1;
        int                 raw2;
        int                 off;
        int                 step;
        int                 idx;
        int                 best;
        int                 dir;
        int                 gap;
        int                 cur;
        int                 angle;
        logic [31:0]        s1;
        logic [31:0]        s2;
        logic [31:0]        cost;
        logic [31:0]        best_cost;
        logic signed [15:0] next_off;

        raw1 = int'(beat.sample_first);
        raw2 = int'(beat.sample_second);
        off  = offset_est / 16;
        s1   = (32'(raw1) - 32'(off)) & 32'h0000_FFFF;
        s2   = (32'(raw2) - 32'(off)) & 32'h0000_FFFF;

        // coarse probe from the predicted index, plus one just over half a table on
        step      = DEPTH / 2 + 1;
        idx       = ring(pred_index);
        best      = idx;
        best_cost = sq_cost(idx, s1, s2);
        for (idx = idx + step; idx < DEPTH; idx += step) begin
            cost = sq_cost(idx, s1, s2);
            if (cost < best_cost) begin
                best      = idx;
                best_cost = cost;
            end
        end

        // halving refinement, direction flips after each gain
        dir = 1;
        while (step != 1) begin
            step = step / 2;
            if (step == 0)
                step = 1;
            idx  = ring(best + step * dir);
            cost = sq_cost(idx, s1, s2);
            if (cost < best_cost) begin
                best      = idx;
                best_cost = cost;
                dir       = -dir;
            end else begin
                idx  = ring(best - step * dir);
                cost = sq_cost(idx, s1, s2);
                if (cost < best_cost) begin
                    best      = idx;
                    best_cost = cost;
                end
            end
        end

        // offset refresh after a large move, plain difference without wrap
        gap = best - anchor_index;
        if (gap < 0)
            gap = -gap;
        if (gap > DEPTH / 10) begin
            anchor_index = best;
            cur = (raw1 - int'(cal_first[best]) + raw2 - int'(cal_second[best])) / 2;
            next_off   = 16'((15 * offset_est) / 16 + cur);
            offset_est = int'(next_off);
        end

        pred_index = ring(best + (best - prev_best));
        prev_best  = best;

        best_cost = best_cost >> 4;
        if (best_cost > {4'd0, peak_level})
            peak_level = best_cost[27:0];

        // a jump of more than half a turn in angle is a wrap through zero
        angle = best * 4096 / DEPTH;
        if (angle - prev_angle > HALF_TURN)
            turn_counts = turn_counts - 32'(TURN_COUNTS);
        else if (angle - prev_angle < -HALF_TURN)
            turn_counts = turn_counts + 32'(TURN_COUNTS);
        prev_angle = angle;

        fix.position   = turn_counts + 32'(angle);
        fix.best_index = 10'(best);
        fix.peak_cost  = peak_level;
        if (beat.clear_peak)
            peak_level = '0;
        return fix;
    endfunction

    // ---------------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // results checked before the same edge's input beat is predicted
    always @(posedge i_clk) begin : result_check
        t_out fix;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (position_fixes.size() == 0) begin
                    report_mismatch("result beat with nothing pending");
                end else begin
                    fix = position_fixes.pop_front();
                    if (o_out_data.position !== fix.position)
                        report_mismatch($sformatf("position got %0d want %0d",
                                        o_out_data.position, fix.position));
                    if (o_out_data.best_index !== fix.best_index)
                        report_mismatch($sformatf("best_index got %0d want %0d",
                                        o_out_data.best_index, fix.best_index));
                    if (o_out_data.peak_cost !== fix.peak_cost)
                        report_mismatch($sformatf("peak_cost got %0d want %0d",
                                        o_out_data.peak_cost, fix.peak_cost));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                if (i_in_data.op == OP_SAMPLE)
                    position_fixes.push_back(track_sample(i_in_data));
                else
                    store_entry(i_in_data);
            end
        end
    end

    // receiver stall: random rate, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // watchdog on cycles without any beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------

    // one input beat, with random idle cycles ahead of it; valid stays high into
    // the next call unless that call idles first
    task automatic send_beat(input t_in beat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // triangle level over one turn; the second column runs a quarter turn ahead
    function automatic int pattern_level(input int k);
        int p;
        p = ((k % DEPTH) + DEPTH) % DEPTH;
        if (p >= DEPTH / 2)
            p = DEPTH - 1 - p;
        return 500 + p * 6;
    endfunction

    function automatic logic [11:0] clamp12(input int v);
        if (v < 0)
            return 12'd0;
        if (v > 4095)
            return 12'd4095;
        return 12'(v);
    endfunction

    // load beat; sample fields and clear_peak are don't-care and random
    function automatic t_in load_beat(input int idx, input int lv1, input int lv2);
        t_in b;
        b               = t_in'({$urandom, $urandom});
        b.op            = OP_LOAD;
        b.entry_index   = 10'(idx);
        b.entry_first   = 12'(lv1);
        b.entry_second  = 12'(lv2);
        return b;
    endfunction

    // sample beat; entry fields are don't-care and random
    function automatic t_in sample_beat(input int lv1, input int lv2, input logic clr);
        t_in b;
        b               = t_in'({$urandom, $urandom});
        b.op            = OP_SAMPLE;
        b.sample_first  = clamp12(lv1);
        b.sample_second = clamp12(lv2);
        b.clear_peak    = clr;
        return b;
    endfunction

    // reading taken near table position k, with a common bias and some noise
    function automatic t_in sample_at(input int k, input int bias, input int noise,
                                      input logic clr);
        int n1;
        int n2;
        n1 = int'($urandom_range(2 * noise)) - noise;
        n2 = int'($urandom_range(2 * noise)) - noise;
        return sample_beat(pattern_level(k) + bias + n1,
                           pattern_level(k + QUARTER) + bias + n2, clr);
    endfunction

    task automatic restore_entry(input int idx);
        send_beat(load_beat(idx, pattern_level(idx), pattern_level(idx + QUARTER)));
    endtask

    // every entry the search can reach is written before any sample
    task automatic fill_table;
        for (int k = 0; k < DEPTH; k++)
            restore_entry(k);
    endtask

    // extreme table levels and sample levels, clear_peak on loads and samples
    task automatic test_extremes;
        t_in b;
        b = load_beat(0, 0, 0);
        b.clear_peak = 1'b1;
        send_beat(b);
        send_beat(load_beat(DEPTH - 1, 4095, 4095));
        send_beat(load_beat(DEPTH / 2 - 1, 4095, 0));
        b = load_beat(DEPTH / 2, 0, 4095);
        b.clear_peak = 1'b1;
        send_beat(b);
        send_beat(sample_beat(0, 0, 1'b0));
        send_beat(sample_beat(4095, 4095, 1'b0));
        send_beat(sample_beat(4095, 0, 1'b1));
        send_beat(sample_beat(0, 4095, 1'b0));
        send_beat(sample_beat(2048, 2048, 1'b1));
        restore_entry(0);
        restore_entry(DEPTH - 1);
        restore_entry(DEPTH / 2 - 1);
        restore_entry(DEPTH / 2);
    endtask

    // walk forward through zero, then back through it
    task automatic test_turn_wrap;
        int stops [7] = '{980, 1010, 20, 50, 5, 1000, 970};
        foreach (stops[n])
            send_beat(sample_at(stops[n], 0, 2, 1'b0));
    endtask

    // large moves under a common bias move the offset estimate both ways
    task automatic test_offset_tracking;
        int stops [6]  = '{200, 400, 650, 900, 100, 350};
        int biases [6] = '{300, 300, 300, 300, -250, -250};
        foreach (stops[n])
            send_beat(sample_at(stops[n], biases[n], 3, n == 3));
    endtask

    // receiver holds off while samples keep coming, so the input side backs up
    task automatic test_input_backpressure;
        int pos;
        pos = 300;
        hold_requests++;
        for (int n = 0; n < 8; n++) begin
            pos += 17;
            send_beat(sample_at(pos, 0, 4, 1'b0));
        end
    endtask

    // mostly tracked samples along a random walk, plus random readings and reloads
    task automatic test_random_walk(input int count);
        int pos;
        int bias;
        int pick;
        int idx;
        pos  = $urandom_range(DEPTH - 1);
        bias = 0;
        for (int n = 0; n < count; n++) begin
            if (n % 25 == 24)
                bias = int'($urandom_range(400)) - 200;
            pick = $urandom_range(99);
            if (pick < 70) begin
                if (pick < 4)
                    pos = $urandom_range(DEPTH - 1);
                else
                    pos = ring(pos + int'($urandom_range(80)) - 40);
                send_beat(sample_at(pos, bias, 6, $urandom_range(9) == 0));
            end else if (pick < 85) begin
                send_beat(sample_beat($urandom_range(4095), $urandom_range(4095),
                                      1'($urandom_range(1))));
            end else begin
                idx = $urandom_range(DEPTH - 1);
                if (pick < 92)
                    restore_entry(idx);
                else
                    send_beat(load_beat(idx, $urandom_range(4095), $urandom_range(4095)));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender slow to idle, receiver stalls most cycles
        send_idle_pct = 11;
        out_stall_pct = 79;
        fill_table();
        test_extremes();
        test_turn_wrap();
        test_offset_tracking();
        test_input_backpressure();
        test_random_walk(150);

        // swapped idle rates
        send_idle_pct = 79;
        out_stall_pct = 11;
        test_random_walk(150);

        // no idling on either side
        send_idle_pct = 0;
        out_stall_pct = 0;
        test_random_walk(150);
        i_in_valid <= 1'b0;

        while (position_fixes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
